@@ hdl/grid_bbox_tile_binner_unit_assert.svh @@
// Assertion macros for the tile binner.
// Included by the top level; needs clk and arst_n in scope.
`ifndef GRID_BBOX_TILE_BINNER_UNIT_ASSERT_SVH
`define GRID_BBOX_TILE_BINNER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define GBT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication checked in the cycle after the antecedent
`define GBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hdl/gbt_pkg.sv @@
// Package for the tile binner: payload structs, sizes, register indexes.
// No dependencies.
`default_nettype none
package gbt_pkg;
	localparam int MaxRowsDef = 16;
	localparam int MaxColsDef = 16;

	localparam logic [2:0] RegOriginX = 3'd0;
	localparam logic [2:0] RegOriginY = 3'd1;
	localparam logic [2:0] RegCellW   = 3'd2;
	localparam logic [2:0] RegCellH   = 3'd3;
	localparam logic [2:0] RegRows    = 3'd4;
	localparam logic [2:0] RegCols    = 3'd5;

	typedef struct packed {
		logic signed [31:0] box_xmin;
		logic signed [31:0] box_ymin;
		logic signed [31:0] box_xmax;
		logic signed [31:0] box_ymax;
		logic               empty_object;
	} in_item_t;

	typedef struct packed {
		logic [8:0]  cell_index;
		logic        is_global;
		logic [31:0] cell_count;
	} out_item_t;

	// request into the division unit
	typedef struct packed {
		logic        start;
		logic [32:0] dividend;
		logic [30:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] quot;
	} div_rsp_t;
endpackage
`default_nettype wire

@@ hdl/grid_bbox_tile_binner_unit.sv @@
// Top level of the tile binner: sequencer, config registers, count memory.
// Depends on gbt_pkg, gbt_divider and grid_bbox_tile_binner_unit_assert.svh.
//
//  channel  | dir | handshake                 | beat
//  cfg      | in  | cfg_valid / cfg_ready     | cfg_index, cfg_data
//  in       | in  | in_valid / in_ready       | in_item (gbt_pkg::in_item_t)
//  out      | out | out_valid / out_ready     | out_item (gbt_pkg::out_item_t)
//
// An item passes the one bit-a-cycle divider four times, once per corner (start,
// 33 shifts, done), then is decoded; when the corners lie in adjacent cells the
// shared compare multiplier tries each cell in turn with four bound tests. The
// chosen cell is then read, written and shown in the states StRd, StRd2, StWr, StOut.
// An empty object is dropped in its beat cycle; in_ready stays high.
// After reset a clearing pass zeroes all MAX_ROWS*MAX_COLS+1 words of the count
// memory; in_ready stays low meanwhile. A result waits in the output register;
// in_ready stays low until it is taken.
`default_nettype none
`include "grid_bbox_tile_binner_unit_assert.svh"
module grid_bbox_tile_binner_unit #(
	parameter int MAX_ROWS = gbt_pkg::MaxRowsDef,
	parameter int MAX_COLS = gbt_pkg::MaxColsDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire gbt_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output gbt_pkg::out_item_t      out_item
);
	import gbt_pkg::*;

	localparam int NCells = MAX_ROWS * MAX_COLS + 1;
	localparam int AW = $clog2(NCells);
	localparam int RW = $clog2(MAX_ROWS + 1);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int PW = (RW > CW) ? RW : CW;

	localparam logic [3:0] StClr  = 4'd0;
	localparam logic [3:0] StIdle = 4'd1;
	localparam logic [3:0] StDiv  = 4'd2;
	localparam logic [3:0] StWait = 4'd3;
	localparam logic [3:0] StDec  = 4'd4;
	localparam logic [3:0] StScan = 4'd5;
	localparam logic [3:0] StRd   = 4'd6;
	localparam logic [3:0] StRd2  = 4'd7;
	localparam logic [3:0] StWr   = 4'd8;
	localparam logic [3:0] StOut  = 4'd9;

	// configuration
	logic signed [31:0] ox_q, oy_q;
	logic [30:0] cw_q, ch_q;
	logic [4:0]  nr_cfg_q, nc_cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q <= '0; oy_q <= '0;
			cw_q <= 31'd65536; ch_q <= 31'd65536;
			nr_cfg_q <= 5'd2; nc_cfg_q <= 5'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegOriginX: ox_q <= cfg_data;
				RegOriginY: oy_q <= cfg_data;
				RegCellW:   cw_q <= cfg_data[30:0];
				RegCellH:   ch_q <= cfg_data[30:0];
				RegRows:    nr_cfg_q <= cfg_data[4:0];
				RegCols:    nc_cfg_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// effective sizes and counts
	logic [30:0] w_eff, h_eff;
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	always_comb begin
		w_eff = (cw_q == '0) ? 31'd1 : cw_q;
		h_eff = (ch_q == '0) ? 31'd1 : ch_q;
		if (nr_cfg_q == '0) nr = RW'(1);
		else if (32'(nr_cfg_q) > MAX_ROWS) nr = RW'(MAX_ROWS);
		else nr = RW'(nr_cfg_q);
		if (nc_cfg_q == '0) nc = CW'(1);
		else if (32'(nc_cfg_q) > MAX_COLS) nc = CW'(MAX_COLS);
		else nc = CW'(nc_cfg_q);
	end

	// item and working registers
	in_item_t    item_q;
	logic [3:0]  state_q;
	logic [1:0]  sel_q;
	logic [PW-1:0] pos_q [4];
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [1:0]  tst_q;
	logic        ok_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] clr_q;
	logic        glob_q;
	logic [31:0] rd_q;
	out_item_t   out_q;
	logic        outv_q;

	// divider feed: corner order ymin, xmin, ymax, xmax
	logic signed [32:0] off;
	logic [30:0] dsor;
	div_req_t dreq;
	div_rsp_t drsp;
	always_comb begin
		case (sel_q)
			2'd0: begin off = 33'(item_q.box_ymin) - 33'(oy_q); dsor = h_eff; end
			2'd1: begin off = 33'(item_q.box_xmin) - 33'(ox_q); dsor = w_eff; end
			2'd2: begin off = 33'(item_q.box_ymax) - 33'(oy_q); dsor = h_eff; end
			default: begin off = 33'(item_q.box_xmax) - 33'(ox_q); dsor = w_eff; end
		endcase
		dreq.start    = (state_q == StDiv);
		dreq.dividend = off[32] ? '0 : off;
		dreq.divisor  = dsor;
	end

	gbt_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// clamp quotient to limit-1
	logic [PW-1:0] lim_m1, qclamp;
	always_comb begin
		lim_m1 = sel_q[0] ? PW'(nc - CW'(1)) : PW'(nr - RW'(1));
		qclamp = (drsp.quot > 33'(lim_m1)) ? lim_m1 : PW'(drsp.quot);
	end

	// shared compare unit: one bound test a cycle
	// tst 0: lx > w*(20c-1), 1: hx < w*(20c+21), 2: ly > ..., 3: hy < ...
	logic signed [38:0] lhs;
	logic signed [13:0] kf;
	logic [30:0]        mf;
	logic signed [45:0] prod;
	logic               pass;
	always_comb begin
		case (tst_q)
			2'd0: lhs = 39'(33'(item_q.box_xmin) - 33'(ox_q)) * 39'sd20;
			2'd1: lhs = 39'(33'(item_q.box_xmax) - 33'(ox_q)) * 39'sd20;
			2'd2: lhs = 39'(33'(item_q.box_ymin) - 33'(oy_q)) * 39'sd20;
			default: lhs = 39'(33'(item_q.box_ymax) - 33'(oy_q)) * 39'sd20;
		endcase
		kf = tst_q[1] ? 14'(r_q) * 14'sd20 : 14'(c_q) * 14'sd20;
		kf = tst_q[0] ? kf + 14'sd21 : kf - 14'sd1;
		mf = tst_q[1] ? h_eff : w_eff;
		prod = 46'(kf) * $signed({15'd0, mf});
		pass = tst_q[0] ? (46'(lhs) < prod) : (46'(lhs) > prod);
	end

	// count memory
	logic [31:0] mem [NCells];
	logic        we;
	logic [AW-1:0] waddr;
	logic [31:0] wdata, newcnt;
	assign newcnt = (rd_q == 32'hFFFF_FFFF) ? rd_q : rd_q + 32'd1;
	always_comb begin
		we    = (state_q == StClr) || (state_q == StWr);
		waddr = (state_q == StClr) ? clr_q : idx_q;
		wdata = (state_q == StClr) ? '0 : newcnt;
	end
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[idx_q];
	end

	logic [AW-1:0] gidx, ridx;
	logic [PW-1:0] dr, dc;
	always_comb begin
		gidx = AW'(nr) * AW'(nc);
		ridx = AW'(r_q) * AW'(nc) + AW'(c_q);
		dr = (pos_q[0] > pos_q[2]) ? pos_q[0] - pos_q[2] : pos_q[2] - pos_q[0];
		dc = (pos_q[1] > pos_q[3]) ? pos_q[1] - pos_q[3] : pos_q[3] - pos_q[1];
	end

	assign in_ready = (state_q == StIdle) && !outv_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StClr;
			clr_q   <= '0;
			outv_q  <= 1'b0;
		end else begin
			if (outv_q && out_ready) outv_q <= 1'b0;
			case (state_q)
				StClr: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NCells - 1)) state_q <= StIdle;
				end
				StIdle: if (in_valid && in_ready) begin
					item_q <= in_item;
					sel_q  <= 2'd0;
					if (!in_item.empty_object) state_q <= StDiv;
				end
				StDiv: state_q <= StWait;
				StWait: if (drsp.done) begin
					pos_q[sel_q] <= qclamp;
					sel_q <= sel_q + 2'd1;
					state_q <= (sel_q == 2'd3) ? StDec : StDiv;
				end
				StDec: begin
					r_q <= '0; c_q <= '0; tst_q <= 2'd0; ok_q <= 1'b1;
					if (pos_q[0] == pos_q[2] && pos_q[1] == pos_q[3]) begin
						idx_q <= AW'(pos_q[0]) * AW'(nc) + AW'(pos_q[1]);
						glob_q <= 1'b0;
						state_q <= StRd;
					end else if (dr < PW'(2) && dc < PW'(2)) begin
						state_q <= StScan;
					end else begin
						idx_q <= gidx; glob_q <= 1'b1;
						state_q <= StRd;
					end
				end
				StScan: begin
					tst_q <= tst_q + 2'd1;
					if (tst_q != 2'd3) ok_q <= ok_q & pass;
					else begin
						ok_q <= 1'b1;
						if (ok_q & pass) begin
							idx_q <= ridx; glob_q <= 1'b0; state_q <= StRd;
						end else if (c_q == nc - CW'(1)) begin
							c_q <= '0;
							if (r_q == nr - RW'(1)) begin
								idx_q <= gidx; glob_q <= 1'b1; state_q <= StRd;
							end else r_q <= r_q + RW'(1);
						end else c_q <= c_q + CW'(1);
					end
				end
				StRd:  state_q <= StRd2;
				StRd2: state_q <= StWr;
				StWr: begin
					out_q.cell_index <= 9'(idx_q);
					out_q.is_global  <= glob_q;
					out_q.cell_count <= newcnt;
					state_q <= StOut;
				end
				StOut: begin
					outv_q <= 1'b1;
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	assign out_valid = outv_q;
	assign out_item  = out_q;

	`GBT_ASSERT_IMPL(a_no_accept_busy, in_valid && in_ready, state_q == StIdle && !outv_q, "input taken while busy")
	`GBT_ASSERT_NEXT(a_out_after_write, state_q == StOut, outv_q, "result not shown after write")
	`GBT_ASSERT_IMPL(a_count_nonzero, outv_q, out_q.cell_count != 32'd0, "zero count shown")
endmodule
`default_nettype wire

@@ hdl/gbt_divider.sv @@
// Restoring divider for the tile binner: one quotient bit a cycle, unsigned.
// Depends on gbt_pkg.
`default_nettype none
module gbt_divider (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gbt_pkg::div_req_t req,
	output gbt_pkg::div_rsp_t      rsp
);
	import gbt_pkg::*;

	logic [32:0] quot_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] trial;
	logic [32:0] diff;

	// shift in next dividend bit and try to subtract
	always_comb begin
		trial = {rem_q[30:0], quot_q[32]};
		diff  = {1'b0, trial} - {2'b00, req.divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q  <= diff[31:0];
				quot_q <= {quot_q[31:0], 1'b1};
			end else begin
				rem_q  <= trial;
				quot_q <= {quot_q[31:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule
`default_nettype wire

@@ sim/grid_bbox_tile_binner_unit_tb.sv @@
// Testbench for grid_bbox_tile_binner_unit: directed and random boxes over several grid setups.
// Depends on gbt_pkg and the block's RTL; a scoreboard class predicts cell index and count.
`timescale 1ns / 1ps
`default_nettype none

class bin_scoreboard;
	logic signed [31:0] org_x, org_y;
	logic [30:0] cw, ch;
	logic [4:0] rows, cols;
	logic [31:0] counts [0:256];
	gbt_pkg::out_item_t pending [$];
	int errors;
	int results;

	function void clear();
		org_x = 0; org_y = 0; cw = 31'd65536; ch = 31'd65536; rows = 5'd2; cols = 5'd2;
		foreach (counts[i]) counts[i] = '0;
		pending.delete();
		errors = 0;
		results = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			gbt_pkg::RegOriginX: org_x = val;
			gbt_pkg::RegOriginY: org_y = val;
			gbt_pkg::RegCellW:   cw = val[30:0];
			gbt_pkg::RegCellH:   ch = val[30:0];
			gbt_pkg::RegRows:    rows = val[4:0];
			gbt_pkg::RegCols:    cols = val[4:0];
			default: ;
		endcase
	endfunction

	// truncated quotient clamped to the grid
	function longint grid_slot(longint coord, longint org, longint size, longint n);
		longint q;
		q = (coord - org) / size;
		if (q < 0) q = 0;
		if (q > n - 1) q = n - 1;
		return q;
	endfunction

	function void note_box(gbt_pkg::in_item_t b);
		longint xmin, ymin, xmax, ymax, ox, oy, w, h, nr, nc;
		longint r0, c0, r1, c1, idx, lx, hx, ly, hy, dr, dc;
		logic [31:0] cnt;
		bit found;
		gbt_pkg::out_item_t res;
		if (b.empty_object) return;
		xmin = b.box_xmin; ymin = b.box_ymin; xmax = b.box_xmax; ymax = b.box_ymax;
		ox = org_x; oy = org_y;
		w = (cw == 0) ? 1 : longint'(cw);
		h = (ch == 0) ? 1 : longint'(ch);
		nr = (rows == 0) ? 1 : (rows > 16 ? 16 : longint'(rows));
		nc = (cols == 0) ? 1 : (cols > 16 ? 16 : longint'(cols));
		r0 = grid_slot(ymin, oy, h, nr);
		c0 = grid_slot(xmin, ox, w, nc);
		r1 = grid_slot(ymax, oy, h, nr);
		c1 = grid_slot(xmax, ox, w, nc);
		dr = r0 > r1 ? r0 - r1 : r1 - r0;
		dc = c0 > c1 ? c0 - c1 : c1 - c0;
		idx = nr * nc;
		if (r0 == r1 && c0 == c1) begin
			idx = r0 * nc + c0;
		end else if (dr < 2 && dc < 2) begin
			lx = 20 * (xmin - ox); hx = 20 * (xmax - ox);
			ly = 20 * (ymin - oy); hy = 20 * (ymax - oy);
			found = 0;
			// first cell in row-major order whose widened bounds hold the box
			for (longint r = 0; r < nr && !found; r++)
				for (longint c = 0; c < nc && !found; c++)
					if (lx > w * (20 * c - 1) && hx < w * (20 * c + 21) &&
						ly > h * (20 * r - 1) && hy < h * (20 * r + 21)) begin
						idx = r * nc + c;
						found = 1;
					end
		end
		cnt = counts[idx];
		if (cnt != 32'hFFFF_FFFF) cnt++;
		counts[idx] = cnt;
		res.cell_index = idx[8:0];
		res.is_global = (idx == nr * nc);
		res.cell_count = cnt;
		pending.push_back(res);
	endfunction

	function void check_result(gbt_pkg::out_item_t got);
		gbt_pkg::out_item_t exp;
		results++;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result idx=%0d glob=%0b cnt=%0d", $time,
				got.cell_index, got.is_global, got.cell_count);
			errors++;
			return;
		end
		exp = pending.pop_front();
		if (got.cell_index !== exp.cell_index) begin
			$display("%0t: cell_index expected %0d got %0d", $time, exp.cell_index,
				got.cell_index);
			errors++;
		end
		if (got.is_global !== exp.is_global) begin
			$display("%0t: is_global expected %0b got %0b", $time, exp.is_global, got.is_global);
			errors++;
		end
		if (got.cell_count !== exp.cell_count) begin
			$display("%0t: cell_count expected %0d got %0d", $time, exp.cell_count,
				got.cell_count);
			errors++;
		end
	endfunction
endclass

module grid_bbox_tile_binner_unit_tb;
	import gbt_pkg::*;

	localparam int StallLimit = 20000;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;

	bin_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	int idle_cycles;
	int boxes_sent;

	grid_bbox_tile_binner_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// take results, stalling at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_item);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: count cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("watchdog expired at %0t", $time);
			$display("grid_bbox_tile_binner_unit_tb failed");
			$finish;
		end
	end

	// hold valid after the beat; the caller drops it once the writes are done
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// idle first, then hold the beat until taken; valid is dropped only while idling
	task automatic send_box(in_item_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_box(b);
		boxes_sent++;
	endtask

	// wait for all results, then allow the block to finish any resultless item
	task automatic drain();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic setup_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] w,
			logic [31:0] h, logic [31:0] nr, logic [31:0] nc);
		write_reg(RegOriginX, ox);
		write_reg(RegOriginY, oy);
		write_reg(RegCellW, w);
		write_reg(RegCellH, h);
		write_reg(RegRows, nr);
		write_reg(RegCols, nc);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t make_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
			logic [31:0] y1, logic e);
		in_item_t b;
		b.box_xmin = x0; b.box_ymin = y0; b.box_xmax = x1; b.box_ymax = y1;
		b.empty_object = e;
		return b;
	endfunction

	// coordinate near a cell edge of the grid, with random jitter around it
	function automatic logic [31:0] grid_coord(logic signed [31:0] org, logic [30:0] sz,
			logic [4:0] n);
		longint s, cells, v;
		s = (sz == 0) ? 1 : sz;
		cells = (n == 0) ? 1 : n;
		v = org + s * $urandom_range(cells) + s * $signed($urandom_range(40) - 20) / 20
			+ $signed($urandom_range(6)) - 3;
		return v[31:0];
	endfunction

	function automatic in_item_t rand_box();
		in_item_t b;
		logic [31:0] x0, y0;
		int mode;
		mode = $urandom_range(99);
		if (mode < 10) begin
			b = make_box($urandom, $urandom, $urandom, $urandom, $urandom_range(1));
		end else begin
			x0 = grid_coord(sb.org_x, sb.cw, sb.cols);
			y0 = grid_coord(sb.org_y, sb.ch, sb.rows);
			b = make_box(x0, y0, x0 + $urandom_range(sb.cw + 2) * (mode < 80 ? 1 : 2),
				y0 + $urandom_range(sb.ch + 2) * (mode < 80 ? 1 : 2), mode < 15);
			if (mode >= 95) b = make_box(b.box_xmax, b.box_ymax, b.box_xmin, b.box_ymin, 0);
		end
		return b;
	endfunction

	initial begin
		sb = new();
		sb.clear();
		arst_n = 0;
		cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; in_item = '0;
		send_idle_pct = 0; recv_stall_pct = 0;
		boxes_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset grid, one box per special case
		send_box(make_box(32'h0000_4000, 32'h0000_4000, 32'h0000_8000, 32'h0000_8000, 0));
		send_box(make_box(32'h0000_4000, 32'h0000_4000, 32'h0000_8000, 32'h0000_8000, 1));
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
		send_box(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		send_box(make_box(32'h0000_F000, 32'h0000_8000, 32'h0001_0800, 32'h0000_9000, 0));
		send_box(make_box(32'h0000_F000, 32'h0000_F000, 32'h0001_0800, 32'h0001_0800, 0));
		send_box(make_box(32'h0001_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_8000, 0));
		send_box(make_box(32'hFFFF_F000, 32'h0000_1000, 32'h0000_8000, 32'h0000_8000, 0));
		drain();
		setup_grid(32'hFFF0_0000, 32'h0010_0000, 32'h0, 32'h0, 32'd0, 32'd0);
		send_box(make_box(32'h0, 32'h0, 32'h1, 32'h1, 0));
		drain();
		setup_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'd31, 32'd17);
		send_box(make_box(32'h0, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 0));
		send_box(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
		drain();
		setup_grid(32'h0, 32'h0, 32'h1, 32'h1, 32'd16, 32'd16);
		send_box(make_box(32'd5, 32'd5, 32'd6, 32'd6, 0));
		send_box(make_box(32'd15, 32'd15, 32'd15, 32'd15, 0));
		send_box(make_box(32'd16, 32'd16, 32'd16, 32'd16, 0));
		drain();
		write_reg(3'd7, 32'hFFFF_FFFF);
		drain();

		// random: several grids and idling phases
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			if (ph == 7)
				setup_grid($urandom, $urandom, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16, 32'd16);
			else
				setup_grid($urandom_range(32'h0040_0000) - 32'h0020_0000,
					$urandom_range(32'h0040_0000) - 32'h0020_0000,
					$urandom_range(32'h0004_0000, 1), $urandom_range(32'h0004_0000, 1),
					$urandom_range(31), $urandom_range(31));
			for (int i = 0; i < 142; i++) send_box(rand_box());
			drain();
		end

		$display("covered %0d boxes and %0d results over twelve grid setups",
			boxes_sent, sb.results);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("grid_bbox_tile_binner_unit_tb passed");
		else
			$display("grid_bbox_tile_binner_unit_tb failed");
		$finish;
	end
endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/gbt_pkg.sv
hdl/gbt_divider.sv
hdl/grid_bbox_tile_binner_unit.sv
sim/grid_bbox_tile_binner_unit_tb.sv
